/* rtl/core/multi_label_hinge_loss_grad_unit_defines.svh */
// Assertion macros for the hinge loss gradient unit.
`ifndef MULTI_LABEL_HINGE_LOSS_GRAD_UNIT_DEFINES_SVH
`define MULTI_LABEL_HINGE_LOSS_GRAD_UNIT_DEFINES_SVH

// Plain property, disabled while in reset.
`define MLHG_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("mlhg check failed");

// Condition implies a consequence on the next clock.
`define MLHG_ASSERT_NXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) else $error("mlhg check failed");

`endif

/* rtl/core/mlhg_pkg.sv */
package mlhg_pkg;

  localparam int GRAD_W   = 26;
  localparam int LOSS_W   = 47;
  localparam int ACC_W    = 64;
  localparam int RECIP_W  = 17;
  localparam int ONE_Q8   = 256;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_TDATA_W = ((GRAD_W + LOSS_W + 7) / 8) * 8;
  localparam logic [RECIP_W-1:0] RECIP_MAX = 17'd65536;

  typedef enum logic [1:0] {
    LBL_NEG     = 2'd0,
    LBL_IGNORE  = 2'd1,
    LBL_POS     = 2'd2,
    LBL_INVALID = 2'd3
  } label_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORM_MODE = 1'b0,
    CFG_RECIP     = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MUL_GRAD    = 2'd0,
    MUL_SQ      = 2'd1,
    MUL_LOSS_LO = 2'd2,
    MUL_LOSS_HI = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     grad_en;
    logic     acc_en;
    logic     part_en;
    logic     loss_en;
    logic     out_wr;
    mul_sel_t mul_sel;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

/* rtl/core/multi_label_hinge_loss_grad_unit.sv */
// Multi-label hinge loss gradient unit.
// Input stream: one score word per element; in_tdata holds the signed score,
// in_tuser the label code, in_tlast marks the final element of a batch.
// Output stream: one word per element with the gradient and the label error
// flag and, on the last element, the scaled batch loss (out_tlast high).
// Configuration: cfg_we with cfg_index 0 writes the norm mode, index 1 the
// batch reciprocal; write only while no element is in flight.
// Flow: an accepted score is decoded into the element register, the gradient
// is registered in ST_GRAD and written out in ST_ACC, or for a batch end in
// ST_LOSS after ST_PART; a new element is taken as a result is written. The shared
// multiplier is used once for the gradient, once for the square, and for
// the loss scaling twice more, on the low and the high accumulator half.
// A stalled output holds its word; one more element is taken and worked
// until its result is ready, then input stalls until the output drains.
// Reset clears the accumulator, the norm mode (L1) and sets the reciprocal
// to one.
module multi_label_hinge_loss_grad_unit #(
  parameter int SCORE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mlhg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlhg_pkg::RECIP_W-1:0]        cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SCORE_WIDTH+7)/8)*8-1:0]    in_tdata,   // score
  input  logic [1:0]                          in_tuser,   // label_code
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mlhg_pkg::OUT_TDATA_W-1:0]    out_tdata,  // gradient, loss
  output logic                                out_tuser,  // label_error
  output logic                                out_tlast
);

  mlhg_pkg::cmd_t    cmd;
  mlhg_pkg::status_t status;

  logic signed [mlhg_pkg::GRAD_W-1:0] grad;
  logic [mlhg_pkg::LOSS_W-1:0]        loss;

  mlhg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mlhg_dp #(
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_score      (in_tdata[SCORE_WIDTH-1:0]),
    .in_code       (in_tuser),
    .in_last       (in_tlast),
    .cmd_i         (cmd),
    .status_o      (status),
    .grad_o        (grad),
    .loss_o        (loss),
    .loss_valid_o  (out_tlast),
    .label_error_o (out_tuser)
  );

  assign out_tdata = mlhg_pkg::OUT_TDATA_W'({loss, grad});

endmodule

/* rtl/core/mlhg_dp.sv */
module mlhg_dp #(
  parameter int SCORE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mlhg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlhg_pkg::RECIP_W-1:0]      cfg_wdata,
  input  logic signed [SCORE_WIDTH-1:0]     in_score,
  input  logic [1:0]                        in_code,
  input  logic                              in_last,
  input  mlhg_pkg::cmd_t                    cmd_i,
  output mlhg_pkg::status_t                 status_o,
  output logic signed [mlhg_pkg::GRAD_W-1:0] grad_o,
  output logic [mlhg_pkg::LOSS_W-1:0]       loss_o,
  output logic                              loss_valid_o,
  output logic                              label_error_o
);

  localparam int MAG_W  = SCORE_WIDTH + 1;
  localparam int D_W    = SCORE_WIDTH + 2;
  localparam int HALF_W = mlhg_pkg::ACC_W / 2;
  localparam int A_W    = (MAG_W > HALF_W) ? MAG_W : HALF_W;
  localparam int B_W    = (MAG_W > mlhg_pkg::RECIP_W) ? MAG_W : mlhg_pkg::RECIP_W;
  localparam int P_W    = A_W + B_W;
  localparam int LO_W   = HALF_W + mlhg_pkg::RECIP_W;
  localparam int PART_W = LO_W - 16;
  localparam int LV_W   = P_W + 17;
  localparam int GW     = mlhg_pkg::GRAD_W;

  localparam logic signed [D_W-1:0] ONE_D = D_W'(mlhg_pkg::ONE_Q8);
  localparam logic [P_W-1:0] GPOS_LIM = P_W'(2**(GW-1) - 1);
  localparam logic [P_W-1:0] GNEG_LIM = P_W'(2**(GW-1));
  localparam logic signed [GW-1:0] GMAX = {1'b0, {(GW-1){1'b1}}};
  localparam logic signed [GW-1:0] GMIN = {1'b1, {(GW-1){1'b0}}};
  localparam logic [LV_W-1:0] LOSS_LIM =
    {{(LV_W-mlhg_pkg::LOSS_W){1'b0}}, {mlhg_pkg::LOSS_W{1'b1}}};

  logic                       norm_mode_r;
  logic [mlhg_pkg::RECIP_W-1:0] recip_r;
  logic [mlhg_pkg::RECIP_W-1:0] r_eff;

  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic             spos_r, spos_nxt;
  logic             sneg_r, sneg_nxt;
  logic             err_r, err_nxt;
  logic             last_r;

  logic signed [D_W-1:0] s_ext, d_plus, d_minus;

  logic [A_W-1:0]             mul_a;
  logic [B_W-1:0]             mul_b;
  logic [P_W-1:0]             prod;
  logic [P_W-1:0]             gm;
  logic [LO_W-1:0]            lo_rnd;
  logic [PART_W-1:0]          part_r;
  logic [LV_W-1:0]            lv;

  logic signed [GW-1:0] grad_r, grad_nxt, g_l1, g_l2;
  logic [mlhg_pkg::ACC_W-1:0] acc_r, acc_nxt, term;
  logic [mlhg_pkg::ACC_W:0]   acc_sum;
  logic [mlhg_pkg::LOSS_W-1:0] loss_nxt;

  // input decode
  assign s_ext   = D_W'(in_score);
  assign d_plus  = ONE_D + s_ext;
  assign d_minus = ONE_D - s_ext;

  always_comb begin
    mag_nxt  = '0;
    spos_nxt = 1'b0;
    sneg_nxt = 1'b0;
    err_nxt  = 1'b0;
    unique case (mlhg_pkg::label_t'(in_code))
      mlhg_pkg::LBL_NEG: begin
        spos_nxt = (d_plus > 0);
        mag_nxt  = (d_plus > 0) ? MAG_W'(d_plus) : '0;
      end
      mlhg_pkg::LBL_POS: begin
        sneg_nxt = (d_minus > 0);
        mag_nxt  = (d_minus > 0) ? MAG_W'(d_minus) : '0;
      end
      mlhg_pkg::LBL_IGNORE: begin
        mag_nxt = '0;
      end
      mlhg_pkg::LBL_INVALID: begin
        spos_nxt = (s_ext > 0);
        sneg_nxt = (s_ext < 0);
        mag_nxt  = (s_ext < 0) ? MAG_W'(-s_ext) : MAG_W'(s_ext);
        err_nxt  = 1'b1;
      end
    endcase
  end

  assign r_eff = (recip_r > mlhg_pkg::RECIP_MAX) ? mlhg_pkg::RECIP_MAX : recip_r;

  // shared multiplier; the loss takes the accumulator in two halves
  always_comb begin
    case (cmd_i.mul_sel)
      mlhg_pkg::MUL_GRAD: begin
        mul_a = A_W'(mag_r);
        mul_b = B_W'(r_eff);
      end
      mlhg_pkg::MUL_SQ: begin
        mul_a = A_W'(mag_r);
        mul_b = B_W'(mag_r);
      end
      mlhg_pkg::MUL_LOSS_LO: begin
        mul_a = A_W'(acc_r[HALF_W-1:0]);
        mul_b = B_W'(r_eff);
      end
      mlhg_pkg::MUL_LOSS_HI: begin
        mul_a = A_W'(acc_r[mlhg_pkg::ACC_W-1:HALF_W]);
        mul_b = B_W'(r_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = P_W'(mul_a) * P_W'(mul_b);

  // gradient
  assign gm = (prod + P_W'(64)) >> 7;

  always_comb begin
    if (sneg_r) begin
      g_l2 = (gm > GNEG_LIM) ? GMIN : -GW'(gm);
      g_l1 = -GW'(r_eff);
    end else begin
      g_l2 = (gm > GPOS_LIM) ? GMAX : GW'(gm);
      g_l1 = spos_r ? GW'(r_eff) : '0;
    end
    grad_nxt = norm_mode_r ? g_l2 : g_l1;
  end

  // saturating accumulate
  assign term    = norm_mode_r ? mlhg_pkg::ACC_W'(prod) : mlhg_pkg::ACC_W'(mag_r);
  assign acc_sum = {1'b0, acc_r} + {1'b0, term};
  assign acc_nxt = acc_sum[mlhg_pkg::ACC_W] ? '1 : acc_sum[mlhg_pkg::ACC_W-1:0];

  // loss = acc * r / 2^16, rounded half up, saturating
  assign lo_rnd   = (prod[LO_W-1:0] + LO_W'(32768)) >> 16;
  assign lv       = (LV_W'(prod) << 16) + LV_W'(part_r);
  assign loss_nxt = (lv > LOSS_LIM) ? '1 : lv[mlhg_pkg::LOSS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_mode_r <= 1'b0;
      recip_r     <= mlhg_pkg::RECIP_MAX;
      acc_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (mlhg_pkg::cfg_idx_t'(cfg_index))
          mlhg_pkg::CFG_NORM_MODE: norm_mode_r <= cfg_wdata[0];
          mlhg_pkg::CFG_RECIP:     recip_r     <= cfg_wdata;
        endcase
      end
      if (cmd_i.loss_en) begin
        acc_r <= '0;
      end else if (cmd_i.acc_en) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      mag_r  <= mag_nxt;
      spos_r <= spos_nxt;
      sneg_r <= sneg_nxt;
      err_r  <= err_nxt;
      last_r <= in_last;
    end
    if (cmd_i.grad_en) begin
      grad_r <= grad_nxt;
    end
    if (cmd_i.part_en) begin
      part_r <= lo_rnd[PART_W-1:0];
    end
    if (cmd_i.out_wr) begin
      grad_o        <= grad_r;
      label_error_o <= err_r;
      loss_o        <= cmd_i.loss_en ? loss_nxt : '0;
      loss_valid_o  <= cmd_i.loss_en;
    end
  end

  assign status_o.last = last_r;

endmodule

/* rtl/core/mlhg_ctrl.sv */
`include "multi_label_hinge_loss_grad_unit_defines.svh"

module mlhg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  mlhg_pkg::status_t status_i,
  output mlhg_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRAD,
    ST_ACC,
    ST_PART,
    ST_LOSS
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd_o         = '0;
    cmd_o.mul_sel = mlhg_pkg::MUL_GRAD;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_GRAD;
      end
      ST_GRAD: begin
        cmd_o.grad_en = 1'b1;
        state_nxt     = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.mul_sel = mlhg_pkg::MUL_SQ;
        if (status_i.last) begin
          cmd_o.acc_en = 1'b1;
          state_nxt    = ST_PART;
        end else if (out_free) begin
          cmd_o.acc_en = 1'b1;
          cmd_o.out_wr = 1'b1;
          in_tready    = 1'b1;
          state_nxt    = in_tvalid ? ST_GRAD : ST_IDLE;
        end
      end
      ST_PART: begin
        cmd_o.mul_sel = mlhg_pkg::MUL_LOSS_LO;
        cmd_o.part_en = 1'b1;
        state_nxt     = ST_LOSS;
      end
      ST_LOSS: begin
        cmd_o.mul_sel = mlhg_pkg::MUL_LOSS_HI;
        if (out_free) begin
          cmd_o.loss_en = 1'b1;
          cmd_o.out_wr  = 1'b1;
          in_tready     = 1'b1;
          state_nxt     = in_tvalid ? ST_GRAD : ST_IDLE;
        end
      end
    endcase
    cmd_o.load = in_tvalid && in_tready;
  end

  assign out_valid_nxt = cmd_o.out_wr ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `MLHG_ASSERT(a_write_free, clk, rst_n, cmd_o.out_wr |-> (!out_valid_r || out_tready))
  `MLHG_ASSERT_NXT(a_write_valid, clk, rst_n, cmd_o.out_wr, out_valid_r)
  `MLHG_ASSERT_NXT(a_load_grad, clk, rst_n, cmd_o.load, cmd_o.grad_en)

endmodule
